[rtl/core/signed_restoring_divider_core_assert.svh]
// Assertion macros for the signed restoring divider checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SIGNED_RESTORING_DIVIDER_CORE_ASSERT_SVH
`define SIGNED_RESTORING_DIVIDER_CORE_ASSERT_SVH

// implication check on an explicit clock and synchronous reset
`define SRDC_ASSERT_CLK(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// same, on the block's own clock and reset names
`define SRDC_ASSERT(name, ante, cons, msg) \
   `SRDC_ASSERT_CLK(name, clock, reset, ante, cons, msg)

`endif

[rtl/core/srd_pkg.sv]
// Shared types, constants and sign-conversion helpers for the divider.
// No dependencies; used by every module of the divider.
package srd_pkg;

   localparam int WIDTH   = 32;          // datapath width, 4..64
   localparam int FIELD_W = 32;          // width of every port field
   localparam int LATENCY = WIDTH + 2;   // prep + one cell per bit + fixup

   typedef logic [WIDTH-1:0]   word_type;
   typedef logic [FIELD_W-1:0] field_type;

   localparam word_type WORD_MIN = {1'b1, {(WIDTH-1){1'b0}}};

   // one item in flight along the cell chain
   typedef struct packed {
      logic     valid;
      word_type rem;     // partial remainder
      word_type quo;     // dividend bits shifting out, quotient bits in
      word_type dvs;     // divisor magnitude
      logic     neg_q;
      logic     neg_r;
      logic     dz;
      logic     ov;
   } stage_type;

   typedef struct packed {
      logic      valid;
      field_type quotient;
      field_type remainder;
      logic      dz;
      logic      ov;
   } result_type;

   // port field -> datapath word: sign-extend, then keep the low WIDTH bits
   function automatic word_type to_word(field_type f);
      logic [63:0] t;
      t = 64'(signed'(f));
      return t[WIDTH-1:0];
   endfunction

   // datapath word -> port field: sign-extend, then keep the low FIELD_W bits
   function automatic field_type to_field(word_type w);
      logic [63:0] t;
      t = 64'(signed'(w));
      return t[FIELD_W-1:0];
   endfunction

endpackage

[rtl/core/srd_prep.sv]
// Entry stage: operand sizing, sign split, magnitudes and special-case flags.
// Depends on srd_pkg.
module srd_prep (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  srd_pkg::field_type  dividend,
   input  srd_pkg::field_type  divisor,
   output srd_pkg::stage_type  stage_out
);

   srd_pkg::word_type  a;
   srd_pkg::word_type  b;
   logic               na;
   logic               nb;
   srd_pkg::stage_type stage_in;
   srd_pkg::stage_type stage_ff;

   always_comb begin
      a  = srd_pkg::to_word(dividend);
      b  = srd_pkg::to_word(divisor);
      na = a[srd_pkg::WIDTH-1];
      nb = b[srd_pkg::WIDTH-1];

      stage_in.valid = accept;
      stage_in.rem   = '0;
      stage_in.quo   = na ? (~a) + srd_pkg::word_type'(1) : a;
      stage_in.dvs   = nb ? (~b) + srd_pkg::word_type'(1) : b;
      stage_in.neg_q = na ^ nb;
      stage_in.neg_r = na;
      stage_in.dz    = (b == '0);
      stage_in.ov    = (a == srd_pkg::WORD_MIN) && (b == '1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

[rtl/core/srd_cell.sv]
// One restoring-division cell: shift, trial subtract, keep or restore.
// Depends on srd_pkg.
module srd_cell (
   input  logic                clock,
   input  logic                reset,
   input  srd_pkg::stage_type  stage_in,
   output srd_pkg::stage_type  stage_out
);

   srd_pkg::word_type       shifted;
   logic [srd_pkg::WIDTH:0] diff;
   logic                    fits;
   srd_pkg::stage_type      next_in;
   srd_pkg::stage_type      next_ff;

   // remainder stays below the divisor magnitude, so its top bit is free
   always_comb begin
      shifted = {stage_in.rem[srd_pkg::WIDTH-2:0], stage_in.quo[srd_pkg::WIDTH-1]};
      diff    = {1'b0, shifted} - {1'b0, stage_in.dvs};
      fits    = ~diff[srd_pkg::WIDTH];

      next_in     = stage_in;
      next_in.rem = fits ? diff[srd_pkg::WIDTH-1:0] : shifted;
      next_in.quo = {stage_in.quo[srd_pkg::WIDTH-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff <= '0;
      end else begin
         next_ff <= next_in;
      end
   end

   assign stage_out = next_ff;

endmodule

[rtl/core/srd_fix.sv]
// Exit stage: sign restore of quotient and remainder, zero-divisor override.
// Depends on srd_pkg.
module srd_fix (
   input  logic                clock,
   input  logic                reset,
   input  srd_pkg::stage_type  stage_in,
   output srd_pkg::result_type result_out
);

   srd_pkg::word_type   q;
   srd_pkg::word_type   r;
   srd_pkg::result_type result_in;
   srd_pkg::result_type result_ff;

   always_comb begin
      q = stage_in.neg_q ? (~stage_in.quo) + srd_pkg::word_type'(1) : stage_in.quo;
      r = stage_in.neg_r ? (~stage_in.rem) + srd_pkg::word_type'(1) : stage_in.rem;
      if (stage_in.dz) begin
         q = '0;
         r = '0;
      end

      result_in.valid     = stage_in.valid;
      result_in.quotient  = srd_pkg::to_field(q);
      result_in.remainder = srd_pkg::to_field(r);
      result_in.dz        = stage_in.dz;
      result_in.ov        = stage_in.ov;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         result_ff <= '0;
      end else begin
         result_ff <= result_in;
      end
   end

   assign result_out = result_ff;

endmodule

[rtl/core/signed_restoring_divider_core.sv]
// Signed restoring divider, fully pipelined: one division accepted every
// clock cycle; each passes one entry stage, one restoring cell per quotient
// bit and one exit stage, all registered.
// busy never rises, so a request is taken on any cycle with start high.
// Each result shows for exactly one cycle with rsp_valid and cannot be
// stalled; results leave in request order. Quotient truncates toward zero,
// remainder carries the dividend's sign. A zero divisor gives zero results
// with rsp_divide_by_zero set; most negative over minus one sets
// rsp_overflowed and the quotient wraps to the most negative value.
// Depends on srd_pkg, srd_prep, srd_cell, srd_fix.
module signed_restoring_divider_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  srd_pkg::field_type  req_dividend,
   input  srd_pkg::field_type  req_divisor,
   output logic                rsp_valid,
   output srd_pkg::field_type  rsp_quotient,
   output srd_pkg::field_type  rsp_remainder,
   output logic                rsp_divide_by_zero,
   output logic                rsp_overflowed
);

   // link[0] is the entry stage output, link[WIDTH] the last cell's output
   srd_pkg::stage_type  link [0:srd_pkg::WIDTH];
   srd_pkg::result_type result;

   // pipeline never backs up, so requests are always welcome
   assign busy = 1'b0;

   srd_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .accept    (start),
      .dividend  (req_dividend),
      .divisor   (req_divisor),
      .stage_out (link[0])
   );

   // chain of cells: cell i settles quotient bit WIDTH-1-i
   for (genvar i = 0; i < srd_pkg::WIDTH; i++) begin : g_cell
      srd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (link[i]),
         .stage_out (link[i+1])
      );
   end

   srd_fix u_fix (
      .clock      (clock),
      .reset      (reset),
      .stage_in   (link[srd_pkg::WIDTH]),
      .result_out (result)
   );

   assign rsp_valid          = result.valid;
   assign rsp_quotient       = result.quotient;
   assign rsp_remainder      = result.remainder;
   assign rsp_divide_by_zero = result.dz;
   assign rsp_overflowed     = result.ov;

endmodule

[rtl/core/srd_checker.sv]
// Port-level checker for the signed restoring divider, bound to the top level.
// Depends on srd_pkg and signed_restoring_divider_core_assert.svh.
`include "signed_restoring_divider_core_assert.svh"

module srd_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input srd_pkg::field_type req_dividend,
   input srd_pkg::field_type req_divisor,
   input logic               rsp_valid,
   input srd_pkg::field_type rsp_quotient,
   input srd_pkg::field_type rsp_remainder,
   input logic               rsp_divide_by_zero,
   input logic               rsp_overflowed
);

   // every response traces back to an earlier accepted request
   `SRDC_ASSERT(a_resp_has_req, rsp_valid, $past(start && !busy, srd_pkg::LATENCY), "response without request")

   // zero divisor: zero results, no overflow
   `SRDC_ASSERT(a_dz_zero, rsp_valid && rsp_divide_by_zero, (rsp_quotient == '0) && (rsp_remainder == '0) && !rsp_overflowed, "divide by zero result not cleared")

   // zero divisor flag matches the divisor that came in
   `SRDC_ASSERT(a_dz_source, rsp_valid && rsp_divide_by_zero, srd_pkg::to_word($past(req_divisor, srd_pkg::LATENCY)) == '0, "divide by zero flag on nonzero divisor")

   // overflow only for the most negative dividend, remainder zero
   `SRDC_ASSERT(a_ov_source, rsp_valid && rsp_overflowed, (srd_pkg::to_word($past(req_dividend, srd_pkg::LATENCY)) == srd_pkg::WORD_MIN) && (rsp_remainder == '0), "overflow flag on wrong operands")

endmodule

bind signed_restoring_divider_core srd_checker u_srd_checker (.*);
